@@ design/wcms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcms_pkg
// Shared constants and types for the windowed channel mean and deviation
// block.
// ----------------------------------------------------------------------------
package wcms_pkg;

    localparam int MAX_CHANNELS_DEF = 64;
    localparam int MAX_WINDOW_DEF   = 256;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int SAMPLE_W   = 24;
    localparam int CC_W       = 7;
    localparam int WL_W       = 9;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 55;
    localparam int CH_OUT_W   = 6;
    localparam int MEAN_W     = 16;
    localparam int DEV_W      = 15;
    localparam int ALU_W      = 64;
    localparam int MEAN_FRAC  = 15;
    localparam int VAR_BITS   = 2 * DEV_W;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CC_W-1:0] CC_RESET = 7'd64;
    localparam logic [WL_W-1:0] WL_RESET = 9'd64;

    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam logic REG_WINDOW_LENGTH = 1'b1;

    localparam logic [MEAN_W-1:0] MEAN_MAX = 16'h7FFF;
    localparam logic [MEAN_W-1:0] MEAN_MIN = 16'h8000;
    localparam logic [DEV_W-1:0]  DEV_MAX  = 15'h7FFF;

    typedef struct packed {
        logic                last;
        logic [CH_OUT_W-1:0] channel;
        logic [SUM_W-1:0]    sum;
        logic [SQ_W-1:0]     sumsq;
    } req_t;

    typedef struct packed {
        logic                last;
        logic [CH_OUT_W-1:0] channel;
        logic [MEAN_W-1:0]   mean;
        logic [DEV_W-1:0]    deviation;
    } res_t;

    typedef struct packed {
        logic             ge;
        logic [ALU_W-1:0] diff;
    } alu_res_t;

endpackage

@@ design/wcms_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcms_alu
// Shared compare and subtract unit used by every division and root step.
// ----------------------------------------------------------------------------
module wcms_alu (
    input  logic [wcms_pkg::ALU_W-1:0] a,
    input  logic [wcms_pkg::ALU_W-1:0] b,
    output wcms_pkg::alu_res_t         res
);
    import wcms_pkg::*;

    logic [ALU_W:0] wide;

    assign wide     = {1'b0, a} - {1'b0, b};
    assign res.ge   = ~wide[ALU_W];
    assign res.diff = wide[ALU_W-1:0];

endmodule

@@ design/wcms_acc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcms_acc
// Per-channel accumulator store with channel and frame counters. Hands the
// closing totals of a window to the statistics sequencer.
// ----------------------------------------------------------------------------
module wcms_acc #(
    parameter int MAX_CHANNELS = wcms_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_WINDOW   = wcms_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS  = wcms_pkg::SAMPLE_BITS_DEF,
    parameter int NCW          = $clog2(MAX_CHANNELS + 1),
    parameter int NW           = $clog2(MAX_WINDOW + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clr,
    input  logic [NCW-1:0]                nch,
    input  logic [NW-1:0]                 n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wcms_pkg::SAMPLE_W-1:0] sample,
    output logic                          req_valid,
    input  logic                          req_ready,
    output wcms_pkg::req_t                req
);
    import wcms_pkg::*;

    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int FW  = $clog2(MAX_WINDOW);

    localparam logic [1:0] AS_IDLE = 2'd0;
    localparam logic [1:0] AS_LOAD = 2'd1;
    localparam logic [1:0] AS_UPD  = 2'd2;
    localparam logic [1:0] AS_HAND = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sumsq;
    } acc_word_t;

    acc_word_t mem [MAX_CHANNELS];

    logic [1:0]                   state_reg, state_next;
    logic [CHW-1:0]               ch_idx_reg, ch_idx_next;
    logic [FW-1:0]                frame_reg, frame_next;
    logic [CHW-1:0]               cur_reg;
    logic [MAX_CHANNELS-1:0]      vld_reg;
    logic signed [SAMPLE_BITS-1:0] v_reg;
    logic signed [2*SAMPLE_BITS-1:0] sq_w;
    logic [SQ_W-1:0]              sq_reg;
    acc_word_t                    rd_reg;
    logic                         rv_reg;
    req_t                         req_reg;

    logic [NCW-1:0]   ch_wide;
    logic [NCW-1:0]   nxt_wide;
    logic [NW-1:0]    fr_wide;
    logic             last_frame;
    logic             wrap;
    logic [SUM_W-1:0] v_ext;
    acc_word_t        wr_word;
    logic             mem_we;

    assign ch_wide    = NCW'(ch_idx_reg);
    assign nxt_wide   = NCW'(cur_reg) + NCW'(1);
    assign fr_wide    = NW'(frame_reg) + NW'(1);
    assign last_frame = (fr_wide >= n);
    assign wrap       = (nxt_wide >= nch);
    assign v_ext      = {{(SUM_W - SAMPLE_BITS){v_reg[SAMPLE_BITS-1]}}, v_reg};
    assign sq_w       = v_reg * v_reg;

    assign wr_word.sum   = (rv_reg ? rd_reg.sum : '0) + v_ext;
    assign wr_word.sumsq = (rv_reg ? rd_reg.sumsq : '0) + sq_reg;
    assign mem_we        = (state_reg == AS_UPD) && !last_frame;

    assign in_ready  = (state_reg == AS_IDLE);
    assign req_valid = (state_reg == AS_HAND);
    assign req       = req_reg;

    always_comb
    begin
        state_next  = state_reg;
        ch_idx_next = ch_idx_reg;
        frame_next  = frame_reg;
        unique case (state_reg)
            AS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = AS_LOAD;
                end
            end
            AS_LOAD:
            begin
                state_next = AS_UPD;
            end
            AS_UPD:
            begin
                state_next = last_frame ? AS_HAND : AS_IDLE;
                if (wrap)
                begin
                    ch_idx_next = '0;
                    frame_next  = last_frame ? '0 : FW'(fr_wide);
                end
                else
                begin
                    ch_idx_next = CHW'(nxt_wide);
                end
            end
            AS_HAND:
            begin
                if (req_ready)
                begin
                    state_next = AS_IDLE;
                end
            end
            default:
            begin
                state_next = AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= AS_IDLE;
            ch_idx_reg <= '0;
            frame_reg  <= '0;
            vld_reg    <= '0;
        end
        else if (clr)
        begin
            state_reg  <= AS_IDLE;
            ch_idx_reg <= '0;
            frame_reg  <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ch_idx_reg <= ch_idx_next;
            frame_reg  <= frame_next;
            if (state_reg == AS_UPD)
            begin
                vld_reg[cur_reg] <= !last_frame;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == AS_IDLE && in_valid)
        begin
            v_reg   <= sample[SAMPLE_BITS-1:0];
            cur_reg <= (ch_wide >= nch) ? '0 : ch_idx_reg;
        end
        sq_reg <= {{(SQ_W - 2*SAMPLE_BITS){1'b0}}, sq_w};
        rv_reg <= vld_reg[cur_reg];
        if (state_reg == AS_UPD && last_frame)
        begin
            req_reg.sum     <= wr_word.sum;
            req_reg.sumsq   <= wr_word.sumsq;
            req_reg.channel <= CH_OUT_W'(cur_reg);
            req_reg.last    <= (nxt_wide == nch);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_reg] <= wr_word;
        end
        rd_reg <= mem[cur_reg];
    end

endmodule

@@ design/wcms_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcms_stats
// Statistics sequencer: mean by restoring division, variance by restoring
// division and deviation by a bit-pair root, all on one shared subtractor.
// ----------------------------------------------------------------------------
module wcms_stats #(
    parameter int MAX_WINDOW = wcms_pkg::MAX_WINDOW_DEF,
    parameter int NW         = $clog2(MAX_WINDOW + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [NW-1:0]  n,
    input  logic           req_valid,
    output logic           req_ready,
    input  wcms_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_ready,
    output wcms_pkg::res_t res
);
    import wcms_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_MCHK = 4'd2;
    localparam logic [3:0] ST_MDIV = 4'd3;
    localparam logic [3:0] ST_NUM  = 4'd4;
    localparam logic [3:0] ST_VCHK = 4'd5;
    localparam logic [3:0] ST_VDIV = 4'd6;
    localparam logic [3:0] ST_ROOT = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    localparam int CNT_W = $clog2(VAR_BITS);
    localparam logic [VAR_BITS-1:0] ROOT_START = VAR_BITS'(1) << (VAR_BITS - 2);

    logic [3:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     abs_reg, abs_next;
    logic                 neg_reg, neg_next;
    logic [SQ_W-1:0]      sumsq_reg, sumsq_next;
    logic [CH_OUT_W-1:0]  ch_reg, ch_next;
    logic                 last_reg, last_next;
    logic [ALU_W-1:0]     p1_reg, p1_next;
    logic [ALU_W-1:0]     p2_reg, p2_next;
    logic [2*NW-1:0]      nn_reg, nn_next;
    logic [ALU_W-1:0]     rem_reg, rem_next;
    logic [ALU_W-1:0]     d_reg, d_next;
    logic [VAR_BITS-1:0]  q_reg, q_next;
    logic [VAR_BITS-1:0]  root_reg, root_next;
    logic [VAR_BITS-1:0]  bit_reg, bit_next;
    logic [MEAN_W-1:0]    mean_reg, mean_next;
    logic [DEV_W-1:0]     dev_reg, dev_next;

    logic [ALU_W-1:0]     alu_a, alu_b;
    alu_res_t             alu_out;
    logic [SQ_W+NW-1:0]   prod_ns;
    logic [ALU_W-1:0]     prod_ss;
    logic [2*NW-1:0]      prod_nn;
    logic [VAR_BITS-1:0]  q_shift;
    logic [VAR_BITS-1:0]  trial;
    logic [VAR_BITS-1:0]  root_step;
    logic [MEAN_W-1:0]    q_mean;

    wcms_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_out)
    );

    assign prod_ns   = sumsq_reg * n;
    assign prod_ss   = abs_reg * abs_reg;
    assign prod_nn   = n * n;
    assign q_shift   = {q_reg[VAR_BITS-2:0], alu_out.ge};
    assign trial     = root_reg + bit_reg;
    assign root_step = alu_out.ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    assign q_mean    = MEAN_W'(q_shift);

    assign req_ready     = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_OUT);
    assign res.last      = last_reg;
    assign res.channel   = ch_reg;
    assign res.mean      = mean_reg;
    assign res.deviation = dev_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        abs_next   = abs_reg;
        neg_next   = neg_reg;
        sumsq_next = sumsq_reg;
        ch_next    = ch_reg;
        last_next  = last_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        nn_next    = nn_reg;
        rem_next   = rem_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        mean_next  = mean_reg;
        dev_next   = dev_reg;
        alu_a      = '0;
        alu_b      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    neg_next   = req.sum[SUM_W-1];
                    abs_next   = req.sum[SUM_W-1] ? (~req.sum + SUM_W'(1)) : req.sum;
                    sumsq_next = req.sumsq;
                    ch_next    = req.channel;
                    last_next  = req.last;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                p1_next    = ALU_W'(prod_ns);
                p2_next    = prod_ss;
                nn_next    = prod_nn;
                state_next = ST_MCHK;
            end
            ST_MCHK:
            begin
                alu_a = ALU_W'(abs_reg);
                alu_b = ALU_W'(n) << MEAN_FRAC;
                if (alu_out.ge)
                begin
                    mean_next  = neg_reg ? MEAN_MIN : MEAN_MAX;
                    state_next = ST_NUM;
                end
                else
                begin
                    rem_next   = ALU_W'(abs_reg);
                    d_next     = ALU_W'(n) << (MEAN_FRAC - 1);
                    q_next     = '0;
                    cnt_next   = CNT_W'(MEAN_FRAC - 1);
                    state_next = ST_MDIV;
                end
            end
            ST_MDIV:
            begin
                alu_a  = rem_reg;
                alu_b  = d_reg;
                q_next = q_shift;
                d_next = d_reg >> 1;
                if (alu_out.ge)
                begin
                    rem_next = alu_out.diff;
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    mean_next  = neg_reg ? (~q_mean + MEAN_W'(1)) : q_mean;
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                alu_a      = p1_reg;
                alu_b      = p2_reg;
                rem_next   = alu_out.diff;
                state_next = ST_VCHK;
            end
            ST_VCHK:
            begin
                alu_a = rem_reg;
                alu_b = ALU_W'(nn_reg) << VAR_BITS;
                if (rem_reg[ALU_W-1])
                begin
                    dev_next   = '0;
                    state_next = ST_OUT;
                end
                else if (alu_out.ge)
                begin
                    dev_next   = DEV_MAX;
                    state_next = ST_OUT;
                end
                else
                begin
                    d_next     = ALU_W'(nn_reg) << (VAR_BITS - 1);
                    q_next     = '0;
                    cnt_next   = CNT_W'(VAR_BITS - 1);
                    state_next = ST_VDIV;
                end
            end
            ST_VDIV:
            begin
                alu_a  = rem_reg;
                alu_b  = d_reg;
                q_next = q_shift;
                d_next = d_reg >> 1;
                if (alu_out.ge)
                begin
                    rem_next = alu_out.diff;
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rem_next   = ALU_W'(q_shift);
                    root_next  = '0;
                    bit_next   = ROOT_START;
                    cnt_next   = CNT_W'(DEV_W - 1);
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                alu_a     = rem_reg;
                alu_b     = ALU_W'(trial);
                root_next = root_step;
                bit_next  = bit_reg >> 2;
                if (alu_out.ge)
                begin
                    rem_next = alu_out.diff;
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    dev_next   = DEV_W'(root_step);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        abs_reg   <= abs_next;
        neg_reg   <= neg_next;
        sumsq_reg <= sumsq_next;
        ch_reg    <= ch_next;
        last_reg  <= last_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        nn_reg    <= nn_next;
        rem_reg   <= rem_next;
        d_reg     <= d_next;
        q_reg     <= q_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        mean_reg  <= mean_next;
        dev_reg   <= dev_next;
    end

endmodule

@@ design/windowed_channel_mean_std.sv @@
`timescale 1ns / 1ps
// An ordinary sample is accepted, its store entry read, then updated and written back.
// A sample in the closing frame of a window goes on to the statistics sequencer,
// which runs a 15-step mean division, a 30-step variance division and a 15-step
// root, all on the one shared subtractor. A saturating mean skips the mean division;
// a saturating deviation or negative variance skips the variance division and root.
// Reset clears all accumulators through per-channel valid bits, zeroes the counters,
// and sets both registers to 64.
// ----------------------------------------------------------------------------
// windowed_channel_mean_std
// Per-channel windowed mean and standard deviation over a stream of samples,
// with an APB register port and a registered result stage.
// ----------------------------------------------------------------------------
module windowed_channel_mean_std #(
    parameter int MAX_CHANNELS = wcms_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_WINDOW   = wcms_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS  = wcms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [23:0] sample
    input  logic [wcms_pkg::SAMPLE_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] channel, [21:6] mean, [36:22] deviation, [39:37] zero
    output logic [wcms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wcms_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wcms_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wcms_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import wcms_pkg::*;

    localparam int NCW = $clog2(MAX_CHANNELS + 1);
    localparam int NW  = $clog2(MAX_WINDOW + 1);

    logic [CC_W-1:0] cc_reg;
    logic [WL_W-1:0] wl_reg;
    logic            cfg_wr;
    logic            reg_idx;
    logic [NCW-1:0]  nch_eff;
    logic [NW-1:0]   n_eff;

    logic req_valid, req_ready;
    req_t req;
    logic res_valid, res_ready;
    res_t res;

    logic out_vld_reg;
    res_t out_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_ADDR_W-1];

    always_comb
    begin
        unique case (reg_idx)
            REG_CHANNEL_COUNT: prdata = APB_DATA_W'(cc_reg);
            REG_WINDOW_LENGTH: prdata = APB_DATA_W'(wl_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= CC_RESET;
            wl_reg <= WL_RESET;
        end
        else if (cfg_wr)
        begin
            if (reg_idx == REG_CHANNEL_COUNT)
            begin
                cc_reg <= pwdata[CC_W-1:0];
            end
            else
            begin
                wl_reg <= pwdata[WL_W-1:0];
            end
        end
    end

    always_comb
    begin
        priority if (cc_reg == '0)
        begin
            nch_eff = NCW'(1);
        end
        else if (32'(cc_reg) > MAX_CHANNELS)
        begin
            nch_eff = NCW'(MAX_CHANNELS);
        end
        else
        begin
            nch_eff = NCW'(cc_reg);
        end
    end

    always_comb
    begin
        priority if (wl_reg < WL_W'(2))
        begin
            n_eff = NW'(2);
        end
        else if (32'(wl_reg) > MAX_WINDOW)
        begin
            n_eff = NW'(MAX_WINDOW);
        end
        else
        begin
            n_eff = NW'(wl_reg);
        end
    end

    wcms_acc #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .NCW          (NCW),
        .NW           (NW)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (cfg_wr),
        .nch       (nch_eff),
        .n         (n_eff),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .sample    (s_axis_tdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    wcms_stats #(
        .MAX_WINDOW (MAX_WINDOW),
        .NW         (NW)
    ) u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n_eff),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = ~out_vld_reg | m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_vld_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = OUT_TDATA_W'({out_reg.deviation, out_reg.mean, out_reg.channel});

endmodule

@@ design/wcms_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcms_checker
// Port-level checks for the windowed channel mean and deviation block.
// ----------------------------------------------------------------------------
module wcms_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [wcms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast,
    input logic                             psel,
    input logic                             pwrite,
    input logic [wcms_pkg::APB_DATA_W-1:0]  prdata
);
    import wcms_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Every sample needs a store read and an update before the next one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("sample accepted during store update");

    // The pad bits above the deviation field stay clear.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:CH_OUT_W+MEAN_W+DEV_W] == '0)
        else $error("pad bits set in result");

    // A register read never shows a value wider than the window-length register.
    a_prdata_range: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite |-> prdata[APB_DATA_W-1:WL_W] == '0)
        else $error("register read out of range");

endmodule

bind windowed_channel_mean_std wcms_checker u_wcms_checker (.*);
